// ----- rtl/core/redc_pkg.sv -----
// shared constants for the roadmap edge distance check
`default_nettype none

package redc_pkg;

	// coordinate width used when no other is given
	localparam int COORD_BITS_DEF = 16;

	// link limit register and distance result
	localparam int             LIMIT_W     = 17;
	localparam logic [16:0]    LIMIT_RESET = 17'd2048;
	localparam logic [16:0]    DIST_MAX    = 17'd131071;

	// configuration port
	localparam int             APB_ADDR_W     = 3;
	localparam int             APB_DATA_W     = 32;
	localparam logic [0:0]     REG_LINK_LIMIT = 1'b0;

	// result word: edge_ok then distance, padded to whole bytes
	localparam int             OUT_DATA_W = 24;

	// depth of the queue between front and back
	localparam int             FIFO_DEPTH = 2;

endpackage

`default_nettype wire

// ----- rtl/core/redc_front.sv -----
// front end: per-joint squared distance and running maximum over a pose pair
`default_nettype none

module redc_front
	import redc_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int SUM_W = (2 * COORD_BITS + 2 > 64) ? 64 : 2 * COORD_BITS + 2
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [COORD_BITS-1:0] ax,
	input  wire logic signed [COORD_BITS-1:0] ay,
	input  wire logic signed [COORD_BITS-1:0] az,
	input  wire logic signed [COORD_BITS-1:0] bx,
	input  wire logic signed [COORD_BITS-1:0] by,
	input  wire logic signed [COORD_BITS-1:0] bz,
	input  wire logic                         pair_allowed,
	input  wire logic                         last_joint,
	output logic                              push_valid,
	input  wire logic                         push_ready,
	output logic [SUM_W:0]                    push_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL0 = 3'd1;
	localparam logic [2:0] ST_MUL1 = 3'd2;
	localparam logic [2:0] ST_MUL2 = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]                state_q;
	logic [COORD_BITS-1:0]     mag_q [3];
	logic                      allowed_q;
	logic                      last_q;
	logic [2*COORD_BITS-1:0]   prod_s1;
	logic [SUM_W-1:0]          sum_q;
	logic [SUM_W-1:0]          max_q;
	logic [COORD_BITS-1:0]     mag_sel;
	logic [SUM_W:0]            sum_ext;
	logic [SUM_W-1:0]          sum_sat;
	logic [SUM_W-1:0]          new_max;
	logic                      fin_ok;
	logic                      accept;
	logic [COORD_BITS-1:0]     mag_in [3];

	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [COORD_BITS:0] d;
		logic        [COORD_BITS:0] m;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		m = d[COORD_BITS] ? -d : d;
		return m[COORD_BITS-1:0];
	endfunction

	assign mag_in[0] = abs_diff(ax, bx);
	assign mag_in[1] = abs_diff(ay, by);
	assign mag_in[2] = abs_diff(az, bz);

	always_comb begin
		case (state_q)
			ST_MUL1: mag_sel = mag_q[1];
			ST_MUL2: mag_sel = mag_q[2];
			default: mag_sel = mag_q[0];
		endcase
	end

	// saturating accumulate of the registered product
	assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(prod_s1);
	assign sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
	assign new_max = (sum_sat > max_q) ? sum_sat : max_q;

	assign fin_ok     = (state_q == ST_FIN) && (!last_q || push_ready);
	assign in_ready   = (state_q == ST_IDLE) || fin_ok;
	assign accept     = in_valid && in_ready;
	assign push_valid = (state_q == ST_FIN) && last_q;
	assign push_data  = {allowed_q, new_max};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			max_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_MUL0;
				end
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_ok) begin
						max_q   <= last_q ? '0 : new_max;
						state_q <= accept ? ST_MUL0 : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q     <= mag_in;
			allowed_q <= pair_allowed;
			last_q    <= last_joint;
		end
		if (state_q == ST_MUL0 || state_q == ST_MUL1 || state_q == ST_MUL2) begin
			prod_s1 <= mag_sel * mag_sel;
		end
		if (state_q == ST_MUL0) begin
			sum_q <= '0;
		end else if (state_q == ST_MUL1 || state_q == ST_MUL2) begin
			sum_q <= sum_sat;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/redc_fifo.sv -----
// short register queue between front and back
`default_nettype none

module redc_fifo
	import redc_pkg::*;
#(
	parameter int W = 35
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [W-1:0] in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [W-1:0]      out_data
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	logic [W-1:0]     mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign in_ready  = cnt_q != CNT_W'(FIFO_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_data;
	end

endmodule

`default_nettype wire

// ----- rtl/core/redc_root.sv -----
// back end: bit-pair integer square root, limit compare and result register
`default_nettype none

module redc_root
	import redc_pkg::*;
#(
	parameter int SUM_W = 34
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [SUM_W:0]     in_data,
	input  wire logic [LIMIT_W-1:0] link_limit,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    out_edge_ok,
	output logic [LIMIT_W-1:0]      out_distance
);

	localparam int ROOT_W = SUM_W / 2;
	localparam int CNT_W  = $clog2(ROOT_W);
	localparam int CMP_W  = (ROOT_W > LIMIT_W) ? ROOT_W : LIMIT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]          state_q;
	logic [SUM_W-1:0]    rad_q;
	logic [ROOT_W+1:0]   rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                allowed_q;
	logic                out_valid_q;
	logic                edge_q;
	logic [LIMIT_W-1:0]  dist_q;
	logic [ROOT_W+1:0]   rem_sh;
	logic [ROOT_W+1:0]   trial;
	logic                ge;
	logic [CMP_W-1:0]    root_ext;
	logic                load_out;

	assign rem_sh = {rem_q[ROOT_W-1:0], rad_q[SUM_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	assign root_ext = CMP_W'(root_q);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign in_ready     = state_q == ST_IDLE;
	assign out_valid    = out_valid_q;
	assign out_edge_ok  = edge_q;
	assign out_distance = dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one just taken
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (cnt_q == CNT_W'(ROOT_W - 1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			rad_q     <= in_data[SUM_W-1:0];
			allowed_q <= in_data[SUM_W];
			rem_q     <= '0;
			root_q    <= '0;
			cnt_q     <= '0;
		end else if (state_q == ST_RUN) begin
			rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], ge};
			cnt_q  <= cnt_q + 1'b1;
		end
		if (load_out) begin
			edge_q <= allowed_q && (root_ext < CMP_W'(link_limit));
			dist_q <= (root_ext > CMP_W'(DIST_MAX)) ? DIST_MAX : root_ext[LIMIT_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/roadmap_edge_distance_check_top.sv -----
// top level of the roadmap edge distance check
//
// one input word per joint of a pose pair: both 3d positions of the joint in
// s_tdata, the pair flag in s_tuser, s_tlast on the final joint. the front
// end takes a new word while idle or as it finishes the last: one shared
// multiplier squares the three axis differences in turn, then the running
// maximum is updated. on the last joint the maximum goes into a two-entry
// queue; the back end takes the floor square root one bit pair per cycle and
// compares it with link_limit. one result word per pair on m_tdata: edge_ok
// in bit 0, distance above it. a last joint passes the front end, the queue,
// the root unit and the output register on its way to m_tvalid. the front
// end works on new joints while the root unit works on an earlier pair; the
// root unit takes a new queue entry only once its result is in the output
// register. while m_tready is low the root unit finishes its root and waits;
// the queue fills, and once it is full s_tready stays low on a last joint.
// reset clears the running maximum, empties the queue and output, and sets
// link_limit to 2048. link_limit is written over the apb port at offset 0.
`default_nettype none

module roadmap_edge_distance_check_top
	import redc_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int IN_DATA_W = ((6 * COORD_BITS + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input word
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // ax, ay, az, bx, by, bz, zero pad
	input  wire logic                  s_tuser,  // pair_allowed
	input  wire logic                  s_tlast,  // last_joint
	// result word
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // edge_ok, distance, zero pad
	// configuration
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	localparam int SUM_W = (2 * COORD_BITS + 2 > 64) ? 64 : 2 * COORD_BITS + 2;

	logic [LIMIT_W-1:0] link_limit_q;
	logic               reg_hit;

	logic               push_valid;
	logic               push_ready;
	logic [SUM_W:0]     push_data;
	logic               pop_valid;
	logic               pop_ready;
	logic [SUM_W:0]     pop_data;

	logic               edge_ok;
	logic [LIMIT_W-1:0] distance;

	// apb register: zero wait states
	assign pready  = 1'b1;
	assign reg_hit = paddr[APB_ADDR_W-1:2] == REG_LINK_LIMIT;
	assign prdata  = reg_hit ? APB_DATA_W'(link_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			link_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// front end: squares and running maximum
	redc_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.ax           (s_tdata[0*COORD_BITS +: COORD_BITS]),
		.ay           (s_tdata[1*COORD_BITS +: COORD_BITS]),
		.az           (s_tdata[2*COORD_BITS +: COORD_BITS]),
		.bx           (s_tdata[3*COORD_BITS +: COORD_BITS]),
		.by           (s_tdata[4*COORD_BITS +: COORD_BITS]),
		.bz           (s_tdata[5*COORD_BITS +: COORD_BITS]),
		.pair_allowed (s_tuser),
		.last_joint   (s_tlast),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	// per-pair maximum and flag waiting for the root unit
	redc_fifo #(
		.W (SUM_W + 1)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_data   (push_data),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_data  (pop_data)
	);

	// back end: square root, compare, output register
	redc_root #(
		.SUM_W (SUM_W)
	) u_root (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (pop_valid),
		.in_ready     (pop_ready),
		.in_data      (pop_data),
		.link_limit   (link_limit_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_edge_ok  (edge_ok),
		.out_distance (distance)
	);

	assign m_tdata = OUT_DATA_W'({distance, edge_ok});

	// an edge is only reported for a distance below the limit
	a_edge_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && edge_ok |-> distance < link_limit_q)
		else $error("edge reported at or above link limit");

	// the front end holds its push while the queue is full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && !push_ready |=> push_valid)
		else $error("front end dropped a pair result");

	// once the root unit takes a queued entry it is no longer ready
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop_ready && pop_valid |=> !pop_ready)
		else $error("root unit took an entry without starting");

endmodule

`default_nettype wire
